// ===== sv/cap_touch_channel_filter_assert.svh =====
// Assertion macros for the touch channel filter.
// Define NO_ASSERTIONS to compile them out; relies on clk and rst_n in scope.
`ifndef CAP_TOUCH_CHANNEL_FILTER_ASSERT_SVH
`define CAP_TOUCH_CHANNEL_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge outside reset
`define CTF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold at the edge that follows ante
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define CTF_ASSERT_ALWAYS(lbl, expr, msg)
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/ctf_pkg.sv =====
// Shared types and constants of the touch channel filter.
// No dependencies; used by ctf_blend and cap_touch_channel_filter.
package ctf_pkg;

  localparam int WEIGHT_W = 8;
  localparam logic [WEIGHT_W:0] WEIGHT_ONE = 9'd256;

  localparam int SAMPLE_W = 16;   // port width of a raw sample / touch value
  localparam int THRESH_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // glitch detector distances
  localparam int GLITCH_NEAR = 5;
  localparam int GLITCH_FAR = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_SMOOTH = 2'd0,
    REG_BASE_SMOOTH = 2'd1,
    REG_THRESHOLD   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] data_smoothing;
    logic [WEIGHT_W-1:0] baseline_smoothing;
    logic [THRESH_W-1:0] touch_threshold;
  } cfg_regs_t;

endpackage

// ===== sv/ctf_blend.sv =====
// Exponential smoother step: new = (x*2^F*(256-w) + old*w) >> 8.
// Depends on ctf_pkg for the weight width.
module ctf_blend #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic [SAMPLE_BITS+FRAC_BITS-1:0] old_acc,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [ctf_pkg::WEIGHT_W-1:0]     weight,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] new_acc
);
  import ctf_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + FRAC_BITS;
  localparam int SUM_W = ACC_W + WEIGHT_W + 1;

  logic [ACC_W-1:0]    fresh;
  logic [WEIGHT_W:0]   inv_weight;
  logic [SUM_W-1:0]    prod_fresh;
  logic [SUM_W-1:0]    prod_old;
  logic [SUM_W-1:0]    sum;

  assign fresh      = {sample, {FRAC_BITS{1'b0}}};
  assign inv_weight = WEIGHT_ONE - {1'b0, weight};
  assign prod_fresh = SUM_W'(fresh) * SUM_W'(inv_weight);
  assign prod_old   = SUM_W'(old_acc) * SUM_W'(weight);
  assign sum        = prod_fresh + prod_old;
  // sum stays below 2^ACC_W * 256, so dropping the low byte fits ACC_W
  assign new_acc    = sum[WEIGHT_W +: ACC_W];

endmodule

// ===== sv/cap_touch_channel_filter.sv =====
// Touch channel filter: calibration average, glitch rejection, fast smoother,
// slow baseline tracker and thresholded difference. Uses ctf_pkg and ctf_blend.
// Throughput: one item per cycle unless out_stall holds the pipeline; three register
// stages in order (input, state, output), which each accepted item passes through.
// Reset (rst_n low, synchronous): pipeline empty, filter state zero, registers
// back to 230 / 254 / 0. No clearing pass; items are taken right after reset.
`include "cap_touch_channel_filter_assert.svh"

module cap_touch_channel_filter #(
  parameter int CAL_SAMPLES      = 20,
  parameter int BASELINE_HOLDOFF = 50,
  parameter int SAMPLE_BITS      = 16,
  parameter int FRAC_BITS        = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ctf_pkg::SAMPLE_W-1:0]       in_raw_sample,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ctf_pkg::SAMPLE_W-1:0]       out_touch_value,
  output logic                               out_calibrating,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ctf_pkg::*;

  localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int LOG_C  = $clog2(CAL_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + LOG_C;      // holds CAL_SAMPLES full-scale samples
  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  // divide by CAL_SAMPLES as multiply by a rounded-up reciprocal; exact for SUM_W bits
  localparam int DIV_SHIFT = SUM_W + LOG_C;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES);

  // ---------------------------------------------------------------- registers
  cfg_regs_t cfg_r;

  assign cfg_ready = 1'b1;  // writes are always taken

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_smoothing     <= 8'd230;
      cfg_r.baseline_smoothing <= 8'd254;
      cfg_r.touch_threshold    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DATA_SMOOTH: cfg_r.data_smoothing     <= cfg_data[WEIGHT_W-1:0];
        REG_BASE_SMOOTH: cfg_r.baseline_smoothing <= cfg_data[WEIGHT_W-1:0];
        REG_THRESHOLD:   cfg_r.touch_threshold    <= cfg_data[THRESH_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Each stage moves when the one after it is empty or moving too, so a new
  // item is taken even while a finished result waits at the output.
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_go, s2_free, s1_go, s1_free;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_go    = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_go;
  assign in_stall = !s1_free;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- stage 1: input
  logic [SAMPLE_BITS-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_sample_r <= in_raw_sample[SAMPLE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- filter state
  logic [SAMPLE_BITS-1:0] hist_middle_r, hist_oldest_r;
  logic [ACC_W-1:0]       smooth_acc_r, baseline_acc_r;
  logic [COUNT_W-1:0]     sample_count_r;
  logic [SUM_W-1:0]       cal_sum_r;
  logic [CNT_W-1:0]       cal_count_r;
  logic                   s2_cal_r;

  logic                   in_cal;
  logic [SUM_W-1:0]       cal_sum_nxt;
  logic [CNT_W-1:0]       cal_count_nxt;
  logic [PROD_W-1:0]      div_prod;
  logic [SAMPLE_BITS-1:0] cal_avg;
  logic [SAMPLE_BITS-1:0] diff_on, diff_mo;
  logic                   glitch;
  logic [SAMPLE_BITS-1:0] middle_fixed;
  logic [ACC_W-1:0]       smooth_nxt, baseline_blend;
  logic                   baseline_on;

  assign in_cal        = cal_count_r < CAL_LAST;
  assign cal_sum_nxt   = cal_sum_r + SUM_W'(s1_sample_r);
  assign cal_count_nxt = cal_count_r + CNT_W'(1);
  assign div_prod      = PROD_W'(cal_sum_nxt) * PROD_W'(RECIP);
  assign cal_avg       = div_prod[DIV_SHIFT +: SAMPLE_BITS];

  // middle sample is an outlier when its neighbors agree and it does not
  assign diff_on = (hist_oldest_r > s1_sample_r) ? hist_oldest_r - s1_sample_r
                                                 : s1_sample_r - hist_oldest_r;
  assign diff_mo = (hist_middle_r > hist_oldest_r) ? hist_middle_r - hist_oldest_r
                                                   : hist_oldest_r - hist_middle_r;
  assign glitch  = (diff_on < SAMPLE_BITS'(GLITCH_NEAR)) &&
                   (diff_mo > SAMPLE_BITS'(GLITCH_FAR));
  assign middle_fixed = glitch ? hist_oldest_r : hist_middle_r;

  assign baseline_on = sample_count_r > COUNT_W'(BASELINE_HOLDOFF);

  ctf_blend #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_smooth (
    .old_acc (smooth_acc_r),
    .sample  (hist_oldest_r),
    .weight  (cfg_r.data_smoothing),
    .new_acc (smooth_nxt)
  );

  ctf_blend #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_baseline (
    .old_acc (baseline_acc_r),
    .sample  (hist_oldest_r),
    .weight  (cfg_r.baseline_smoothing),
    .new_acc (baseline_blend)
  );

  // stage 2: state registers always describe the item held in stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r     <= 1'b0;
      hist_middle_r  <= '0;
      hist_oldest_r  <= '0;
      smooth_acc_r   <= '0;
      baseline_acc_r <= '0;
      sample_count_r <= '0;
      cal_sum_r      <= '0;
      cal_count_r    <= '0;
    end else begin
      if (s2_free) begin
        s2_valid_r <= s1_go;
      end
      if (s1_go) begin
        if (in_cal) begin
          cal_sum_r   <= cal_sum_nxt;
          cal_count_r <= cal_count_nxt;
          if (cal_count_nxt == CAL_LAST) begin
            // seed history and both smoothers with the truncated average
            hist_middle_r  <= cal_avg;
            hist_oldest_r  <= cal_avg;
            smooth_acc_r   <= {cal_avg, {FRAC_BITS{1'b0}}};
            baseline_acc_r <= {cal_avg, {FRAC_BITS{1'b0}}};
          end
        end else begin
          smooth_acc_r <= smooth_nxt;
          if (baseline_on) begin
            baseline_acc_r <= baseline_blend;
          end
          if (sample_count_r < COUNT_MAX) begin
            sample_count_r <= sample_count_r + COUNT_W'(1);
          end
          hist_oldest_r <= middle_fixed;
          hist_middle_r <= s1_sample_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_cal_r <= in_cal;
    end
  end

  // ---------------------------------------------------------------- stage 3: result
  logic [ACC_W-1:0]       acc_diff;
  logic [SAMPLE_BITS-1:0] diff_int;
  logic [SAMPLE_W-1:0]    touch_nxt;

  assign acc_diff = smooth_acc_r - baseline_acc_r;
  assign diff_int = acc_diff[FRAC_BITS +: SAMPLE_BITS];

  always_comb begin
    touch_nxt = '0;
    // negative difference, values under threshold and calibration all report zero
    if (!s2_cal_r && (smooth_acc_r > baseline_acc_r)) begin
      if (SAMPLE_W'(diff_int) >= cfg_r.touch_threshold) begin
        touch_nxt = SAMPLE_W'(diff_int);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_touch_value <= touch_nxt;
      out_calibrating <= s2_cal_r;
    end
  end

  // ---------------------------------------------------------------- checks
  `CTF_ASSERT_ALWAYS(a_cal_count_bound, cal_count_r <= CAL_LAST, "calibration count overrun")
  `CTF_ASSERT_ALWAYS(a_count_after_cal, (sample_count_r == '0) || (cal_count_r == CAL_LAST), "samples counted before calibration end")
  `CTF_ASSERT_ALWAYS(a_cal_output_zero, !(out_valid_r && out_calibrating) || (out_touch_value == '0), "nonzero value while calibrating")
  `CTF_ASSERT_NEXT(a_cal_done_sticks, cal_count_r == CAL_LAST, cal_count_r == CAL_LAST, "calibration restarted")

endmodule

// ===== dv/tb_cap_touch_channel_filter.sv =====
// Self-checking testbench for cap_touch_channel_filter: calibration, glitch rejection,
// fast smoother, baseline tracker and threshold, with random idling on both channels.
// Depends on ctf_pkg and the RTL of cap_touch_channel_filter only.
module tb_cap_touch_channel_filter;
  import ctf_pkg::*;

  // Block parameters, kept at their defaults but passed explicitly so the
  // predictor and the instance agree.
  localparam int CAL_LEN = 20;
  localparam int HOLDOFF = 50;
  localparam int QUIET_LIMIT = 4000;  // cycles with no handshake at all
  localparam int SETTLE = 6;          // idle margin after the pipeline drains
  localparam int PHASES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not decoded, must be ignored

  typedef struct packed {
    logic [SAMPLE_W-1:0] touch_value;
    logic                calibrating;
  } touch_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_raw_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_touch_value;
  logic out_calibrating;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Filter state as the block should hold it
  logic [7:0]  w_fast, w_base;
  logic [15:0] min_touch;
  logic [15:0] hist_mid, hist_old;
  logic [23:0] fast_acc, base_acc;
  logic [5:0]  settle_count;
  logic [20:0] cal_total;
  logic [4:0]  cal_taken;

  logic [SAMPLE_W-1:0] pending_samples[$];
  touch_result_t       touch_expect[$];

  int n_sent = 0;        // items put on the input port (driver only)
  int n_taken = 0;       // items accepted (monitor only)
  int n_results = 0;
  int n_reg_writes = 0;
  int n_glitch_fixes = 0;
  int n_touches = 0;     // nonzero touch values predicted
  int errors = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int trace_level = 0;   // current sensor level of the random trace

  cap_touch_channel_filter #(
    .CAL_SAMPLES(CAL_LEN),
    .BASELINE_HOLDOFF(HOLDOFF),
    .SAMPLE_BITS(16),
    .FRAC_BITS(8)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_raw_sample(in_raw_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_touch_value(out_touch_value),
    .out_calibrating(out_calibrating),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exponential smoother step in 16.8 fixed point; w is the weight on the
  // old value in 1/256 units. The shift truncates, values never go negative.
  function automatic logic [23:0] ema_update(logic [23:0] prev, logic [15:0] x,
                                             logic [7:0] w);
    logic [40:0] fresh, sum;
    fresh = {17'd0, x, 8'd0};
    sum = fresh * (41'd256 - {33'd0, w}) + {17'd0, prev} * {33'd0, w};
    return sum[31:8];
  endfunction

  function automatic logic [15:0] abs_gap(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function void reset_filter_model();
    w_fast = 8'd230;
    w_base = 8'd254;
    min_touch = 16'd0;
    hist_mid = '0;
    hist_old = '0;
    fast_acc = '0;
    base_acc = '0;
    settle_count = '0;
    cal_total = '0;
    cal_taken = '0;
  endfunction

  // Only the low byte of a weight write is kept; the spare index does nothing.
  function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DATA_SMOOTH: w_fast = data[7:0];
      REG_BASE_SMOOTH: w_base = data[7:0];
      REG_THRESHOLD:   min_touch = data[15:0];
      default: ;
    endcase
  endfunction

  function void predict_touch(logic [15:0] raw);
    touch_result_t r;
    logic [20:0] avg;
    logic [23:0] gap;
    r.touch_value = '0;
    r.calibrating = 1'b0;
    if (cal_taken < CAL_LEN) begin
      // calibration: sum, then seed every state with the truncated mean
      cal_total = cal_total + {5'd0, raw};
      cal_taken = cal_taken + 5'd1;
      if (cal_taken == CAL_LEN) begin
        avg = 21'(cal_total / CAL_LEN);
        hist_mid = avg[15:0];
        hist_old = avg[15:0];
        fast_acc = {avg[15:0], 8'd0};
        base_acc = {avg[15:0], 8'd0};
      end
      r.calibrating = 1'b1;
    end else begin
      // outlying middle sample between two close neighbors is replaced
      if (abs_gap(hist_old, raw) < GLITCH_NEAR && abs_gap(hist_mid, hist_old) > GLITCH_FAR) begin
        hist_mid = hist_old;
        n_glitch_fixes++;
      end
      fast_acc = ema_update(fast_acc, hist_old, w_fast);
      if (settle_count > HOLDOFF)
        base_acc = ema_update(base_acc, hist_old, w_base);
      if (settle_count < COUNT_MAX)
        settle_count = settle_count + 6'd1;
      hist_old = hist_mid;
      hist_mid = raw;
      // falling below the baseline reports zero
      if (fast_acc > base_acc) begin
        gap = fast_acc - base_acc;
        r.touch_value = gap[23:8];
        if (r.touch_value < min_touch)
          r.touch_value = '0;
      end
      if (r.touch_value != 0)
        n_touches++;
    end
    touch_expect.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge. A new item is presented only
  // once the previous one was taken, so a stalled item holds still.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (n_taken == n_sent) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_raw_sample <= pending_samples.pop_front();
          in_valid <= 1'b1;
          n_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every handshake is seen at the rising edge. Register writes and
  // accepted items update the predictor; results are checked in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    touch_result_t want;
    logic busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        n_reg_writes++;
        busy = 1'b1;
      end
      if (in_valid && !in_stall) begin
        predict_touch(in_raw_sample);
        n_taken++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        n_results++;
        if (touch_expect.size() == 0) begin
          $display("%0t: unexpected result: touch_value %0d calibrating %0b", $time,
                   out_touch_value, out_calibrating);
          errors++;
        end else begin
          want = touch_expect.pop_front();
          if (out_touch_value !== want.touch_value) begin
            $display("%0t: touch_value mismatch: expected %0d, actual %0d", $time,
                     want.touch_value, out_touch_value);
            errors++;
          end
          if (out_calibrating !== want.calibrating) begin
            $display("%0t: calibrating mismatch: expected %0b, actual %0b", $time,
                     want.calibrating, out_calibrating);
            errors++;
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  // Hang guard: a lost result or a stuck handshake ends the run here.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT)
      @(negedge clk);
    $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
             QUIET_LIMIT, touch_expect.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int clamp16(int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // Sensor-like trace: mostly a level with a few counts of noise (this is what
  // exercises the glitch window edges), plus spikes, touch steps up and down,
  // rail-to-rail levels and some plain noise.
  task automatic queue_sensor_trace(input int count);
    int sel, v, d;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        v = $urandom_range(65535);
      end else if (sel < 15) begin
        d = $urandom_range(2000, 4);
        v = $urandom_range(1) ? trace_level + d : trace_level - d;
      end else if (sel < 19) begin
        case ($urandom_range(3))
          0: trace_level = $urandom_range(400);
          1: trace_level = 65535 - int'($urandom_range(400));
          default: begin
            d = $urandom_range(6000, 50);
            trace_level = $urandom_range(1) ? trace_level + d : trace_level - d;
          end
        endcase
        trace_level = clamp16(trace_level);
        v = trace_level;
      end else begin
        if ($urandom_range(9) == 0)
          trace_level = clamp16(trace_level + int'($urandom_range(2)) - 1);
        v = trace_level + int'($urandom_range(12)) - 6;
      end
      pending_samples.push_back(16'(clamp16(v)));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender holds off until every item has been answered.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || n_taken != n_sent || touch_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sum, base, ds, bs, th;
    logic [15:0] cal_seq[CAL_LEN];
    reset_filter_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: calibration with both rails and alternating bit patterns,
    // then two glitches that get replaced and a sample inside the near window.
    sum = 0;
    for (int i = 0; i < CAL_LEN; i++) begin
      case (i)
        0: cal_seq[i] = 16'h0000;
        1: cal_seq[i] = 16'hFFFF;
        2: cal_seq[i] = 16'hAAAA;
        3: cal_seq[i] = 16'h5555;
        default: cal_seq[i] = 16'h8000 + 16'(i * 7);
      endcase
      sum += cal_seq[i];
      pending_samples.push_back(cal_seq[i]);
    end
    base = sum / CAL_LEN;
    pending_samples.push_back(16'(base + 10));  // spike in the middle slot
    pending_samples.push_back(16'(base + 2));   // close to oldest: spike replaced
    pending_samples.push_back(16'(base + 7));
    pending_samples.push_back(16'(base + 2));
    pending_samples.push_back(16'(base + 5));   // three from the oldest: inside the near limit
    trace_level = base;
    queue_sensor_trace(215);
    wait_drained();

    // Register sweeps, each with one of four idling patterns. The spare index is
    // written too, and weight writes carry junk in the upper byte.
    for (int p = 1; p < PHASES; p++) begin
      case (p)
        1: begin ds = 0;   bs = 0;   th = 0;     src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin ds = 255; bs = 255; th = 65535; src_idle_pct = 0;  sink_stall_pct = 58; end
        3: begin ds = 128; bs = 200; th = 16;    src_idle_pct = 18; sink_stall_pct = 18; end
        4: begin
          ds = $urandom_range(255); bs = $urandom_range(255); th = $urandom_range(300);
          src_idle_pct = 0; sink_stall_pct = 0;
        end
        5: begin ds = 255; bs = 0;   th = 0;     src_idle_pct = 58; sink_stall_pct = 0;  end
        6: begin ds = 1;   bs = 255; th = 1;     src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin
          ds = $urandom_range(255); bs = $urandom_range(255); th = $urandom_range(65535);
          src_idle_pct = 18; sink_stall_pct = 18;
        end
      endcase
      write_reg(REG_DATA_SMOOTH, {8'($urandom_range(255)), 8'(ds)});
      write_reg(REG_BASE_SMOOTH, {8'($urandom_range(255)), 8'(bs)});
      write_reg(REG_THRESHOLD, 16'(th));
      write_reg(REG_SPARE, 16'($urandom_range(65535)));
      queue_sensor_trace(237);
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d samples and %0d results over %0d register settings (%0d writes).",
             n_taken, n_results, PHASES, n_reg_writes);
    $display("Saw %0d glitch replacements and %0d nonzero touch values.",
             n_glitch_fixes, n_touches);
    if (errors == 0 && touch_expect.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ctf_pkg.sv
sv/ctf_blend.sv
sv/cap_touch_channel_filter.sv
dv/tb_cap_touch_channel_filter.sv
